// ===== hw/rtl/nsq_pkg.sv =====
// Shared codes and types for the named stack/queue engine.
`timescale 1ns / 1ps
`default_nettype none
package nsq_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 32;

  // actions
  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STAT_CREATED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_PUSHED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_POPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EXISTS  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOLIST  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd6;

  // input word layout
  localparam int IN_TDATA_W  = 40;
  localparam int IN_ACT_LO   = 0;
  localparam int IN_ID_LO    = 2;
  localparam int IN_STACK_LO = 6;
  localparam int IN_VALUE_LO = 7;

  // output word layout
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_STAT_LO  = 0;
  localparam int OUT_VALUE_LO = 3;

  // per-list flag update
  typedef struct packed {
    logic create;
    logic make_stack;
    logic set_nonempty;
    logic clr_nonempty;
  } flag_op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nsq_node_store.sv =====
// Node pool storage: link and value memories with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module nsq_node_store #(
  parameter int NODES      = 256,
  parameter int DATA_WIDTH = 32,
  parameter int NW         = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [NW-1:0]         rd_addr,
  output logic      [NW-1:0]         link_q,
  output logic      [DATA_WIDTH-1:0] value_q,
  input  wire logic                  link_we,
  input  wire logic [NW-1:0]         link_waddr,
  input  wire logic [NW-1:0]         link_wdata,
  input  wire logic                  value_we,
  input  wire logic [NW-1:0]         value_waddr,
  input  wire logic [DATA_WIDTH-1:0] value_wdata
);

  logic [NW-1:0]         link_mem  [NODES];
  logic [DATA_WIDTH-1:0] value_mem [NODES];

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      link_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    if (rd_en) begin
      value_q <= value_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/nsq_list_table.sv =====
// List table: per-list flags in flops, head and tail pointers in memories.
`timescale 1ns / 1ps
`default_nettype none
module nsq_list_table #(
  parameter int LISTS = 16,
  parameter int NW    = 8,
  parameter int HW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [HW-1:0]     id,
  output logic                   in_use,
  output logic                   is_stack,
  output logic                   nonempty,
  input  wire nsq_pkg::flag_op_t flag_op,
  input  wire logic              rd_en,
  input  wire logic [HW-1:0]     rd_id,
  output logic      [NW-1:0]     head_q,
  output logic      [NW-1:0]     tail_q,
  input  wire logic              head_we,
  input  wire logic [NW-1:0]     head_wdata,
  input  wire logic              tail_we,
  input  wire logic [NW-1:0]     tail_wdata
);

  // only ids that fit the four-bit field can ever be addressed
  localparam int HDEPTH = (LISTS < 16) ? LISTS : 16;

  logic [HDEPTH-1:0] in_use_bits;
  logic [HDEPTH-1:0] stack_bits;
  logic [HDEPTH-1:0] nonempty_bits;
  logic [NW-1:0]     head_mem [HDEPTH];
  logic [NW-1:0]     tail_mem [HDEPTH];

  assign in_use   = in_use_bits[id];
  assign is_stack = stack_bits[id];
  assign nonempty = nonempty_bits[id];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use_bits   <= '0;
      stack_bits    <= '0;
      nonempty_bits <= '0;
    end else begin
      if (flag_op.create) begin
        in_use_bits[id]   <= 1'b1;
        stack_bits[id]    <= flag_op.make_stack;
        nonempty_bits[id] <= 1'b0;
      end
      if (flag_op.set_nonempty) begin
        nonempty_bits[id] <= 1'b1;
      end
      if (flag_op.clr_nonempty) begin
        nonempty_bits[id] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[id] <= head_wdata;
    end
    if (rd_en) begin
      head_q <= head_mem[rd_id];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[id] <= tail_wdata;
    end
    if (rd_en) begin
      tail_q <= tail_mem[rd_id];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/named_stack_queue_engine.sv =====
// Top level of the named stack/queue engine: command sequencer and free pool.
//
//  port group  | dir | word fields (lowest bit up)
//  s_axis      | in  | action[1:0] list_id[5:2] make_stack[6] push_value[38:7], pad
//  m_axis      | out | status[2:0] pop_value[34:3], pad
//
// Create and push finish in the EXEC state; pop goes on to the POP state. The list
// header memory is read on accept, the node memory at the head is read in EXEC.
// One command is in flight at a time; the next word is taken once the result sits
// in the output register, even if it is not yet taken.
// A stalled output holds the finishing command, and no memory is written until the
// output register frees. Reset clears only state, m_tvalid, flags and pool registers.
`timescale 1ns / 1ps
`default_nettype none
module named_stack_queue_engine #(
  parameter int LISTS      = 16,
  parameter int NODES      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // action, list_id, make_stack, push_value, zero pad
  input  wire logic [nsq_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // status, pop_value, zero pad
  output logic      [nsq_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW     = $clog2(NODES + 1);
  localparam int HDEPTH = (LISTS < 16) ? LISTS : 16;
  localparam int HW     = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int WW     = nsq_pkg::WORD_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [nsq_pkg::ACTION_W-1:0] cmd_action;
  logic [nsq_pkg::ID_W-1:0]     cmd_id;
  logic                         cmd_stack;
  logic [WW-1:0]                cmd_value;

  logic [NW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] fresh_count;

  logic accept;
  logic out_free;
  logic out_load;
  logic go_pop;

  logic [nsq_pkg::ID_W-1:0] in_id;
  logic                     in_id_ok;
  logic                     cmd_id_ok;
  logic [HW-1:0]            lid;

  logic          in_use;
  logic          is_stack;
  logic          nonempty;
  logic [NW-1:0] head_q;
  logic [NW-1:0] tail_q;
  logic [NW-1:0] link_q;
  logic [DATA_WIDTH-1:0] value_q;

  nsq_pkg::flag_op_t flag_op;
  logic          head_we;
  logic [NW-1:0] head_wdata;
  logic          tail_we;
  logic [NW-1:0] tail_wdata;
  logic          link_we;
  logic [NW-1:0] link_waddr;
  logic [NW-1:0] link_wdata;
  logic          value_we;
  logic          node_rd_en;
  logic [NW-1:0] node_rd_addr;

  logic          from_free;
  logic          have_node;
  logic [NW-1:0] new_node;
  logic          take_free;
  logic          take_fresh;
  logic          give_node;

  logic [nsq_pkg::STATUS_W-1:0] status_next;
  logic [WW-1:0]                pop_next;
  logic [DATA_WIDTH-1:0]        store_value;
  logic [WW-1:0]                popped_word;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign in_id     = s_tdata[nsq_pkg::IN_ID_LO +: nsq_pkg::ID_W];
  assign in_id_ok  = (32'(in_id) < LISTS);
  assign cmd_id_ok = (32'(cmd_id) < LISTS);
  assign lid       = cmd_id[HW-1:0];

  assign from_free = (free_count != '0);
  assign have_node = from_free || (fresh_count < CW'(NODES));
  assign new_node  = from_free ? free_head : fresh_count[NW-1:0];

  // width change between the 32-bit port and stored data
  generate
    if (DATA_WIDTH > WW) begin : g_wide
      assign store_value = {{(DATA_WIDTH - WW){1'b0}}, cmd_value};
      assign popped_word = value_q[WW-1:0];
    end else if (DATA_WIDTH == WW) begin : g_same
      assign store_value = cmd_value;
      assign popped_word = value_q;
    end else begin : g_narrow
      assign store_value = cmd_value[DATA_WIDTH-1:0];
      assign popped_word = {{(WW - DATA_WIDTH){value_q[DATA_WIDTH-1]}}, value_q};
    end
  endgenerate

  always_comb begin
    status_next = nsq_pkg::STAT_NOLIST;
    pop_next    = '0;
    out_load    = 1'b0;
    go_pop      = 1'b0;
    flag_op     = '0;
    head_we     = 1'b0;
    head_wdata  = new_node;
    tail_we     = 1'b0;
    tail_wdata  = new_node;
    link_we     = 1'b0;
    link_waddr  = new_node;
    link_wdata  = head_q;
    value_we    = 1'b0;
    take_free   = 1'b0;
    take_fresh  = 1'b0;
    give_node   = 1'b0;
    case (state)
      S_EXEC: begin
        if (cmd_id_ok && cmd_action == nsq_pkg::ACT_CREATE) begin
          if (in_use) begin
            status_next = nsq_pkg::STAT_EXISTS;
          end else begin
            status_next        = nsq_pkg::STAT_CREATED;
            flag_op.create     = out_free;
            flag_op.make_stack = cmd_stack;
          end
        end else if (cmd_id_ok && cmd_action == nsq_pkg::ACT_PUSH && in_use) begin
          if (!have_node) begin
            status_next = nsq_pkg::STAT_FULL;
          end else begin
            status_next = nsq_pkg::STAT_PUSHED;
            value_we    = out_free;
            take_free   = out_free && from_free;
            take_fresh  = out_free && !from_free;
            if (!nonempty) begin
              head_we              = out_free;
              tail_we              = out_free;
              flag_op.set_nonempty = out_free;
            end else if (is_stack) begin
              link_we = out_free;
              head_we = out_free;
            end else begin
              // queue: old tail now points at the new node
              link_we    = out_free;
              link_waddr = tail_q;
              link_wdata = new_node;
              tail_we    = out_free;
            end
          end
        end else if (cmd_id_ok && cmd_action == nsq_pkg::ACT_POP && in_use) begin
          if (!nonempty) begin
            status_next = nsq_pkg::STAT_EMPTY;
          end else begin
            go_pop = 1'b1;
          end
        end
        out_load = !go_pop && out_free;
      end
      S_POP: begin
        status_next = nsq_pkg::STAT_POPPED;
        pop_next    = popped_word;
        out_load    = out_free;
        give_node   = out_free;
        // freed node goes on top of the free list
        link_we     = out_free;
        link_waddr  = head_q;
        link_wdata  = free_head;
        if (head_q == tail_q) begin
          flag_op.clr_nonempty = out_free;
        end else begin
          head_we    = out_free;
          head_wdata = link_q;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // accept reads the header and the top of the free list; pop reads at the head
  assign node_rd_en   = accept || go_pop;
  assign node_rd_addr = go_pop ? head_q : free_head;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go_pop) begin
          state_next = S_POP;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      free_head   <= '0;
      free_count  <= '0;
      fresh_count <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (take_free) begin
        free_head  <= link_q;
        free_count <= free_count - CW'(1);
      end
      if (take_fresh) begin
        fresh_count <= fresh_count + CW'(1);
      end
      if (give_node) begin
        free_head  <= head_q;
        free_count <= free_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_action <= s_tdata[nsq_pkg::IN_ACT_LO +: nsq_pkg::ACTION_W];
      cmd_id     <= in_id;
      cmd_stack  <= s_tdata[nsq_pkg::IN_STACK_LO];
      cmd_value  <= s_tdata[nsq_pkg::IN_VALUE_LO +: WW];
    end
    if (out_load) begin
      m_tdata <= {{(nsq_pkg::OUT_TDATA_W - nsq_pkg::STATUS_W - WW){1'b0}},
                  pop_next, status_next};
    end
  end

  nsq_list_table #(
    .LISTS (LISTS),
    .NW    (NW),
    .HW    (HW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .id         (lid),
    .in_use     (in_use),
    .is_stack   (is_stack),
    .nonempty   (nonempty),
    .flag_op    (flag_op),
    .rd_en      (accept && in_id_ok),
    .rd_id      (in_id[HW-1:0]),
    .head_q     (head_q),
    .tail_q     (tail_q),
    .head_we    (head_we),
    .head_wdata (head_wdata),
    .tail_we    (tail_we),
    .tail_wdata (tail_wdata)
  );

  nsq_node_store #(
    .NODES      (NODES),
    .DATA_WIDTH (DATA_WIDTH),
    .NW         (NW)
  ) u_nodes (
    .clk         (clk),
    .rd_en       (node_rd_en),
    .rd_addr     (node_rd_addr),
    .link_q      (link_q),
    .value_q     (value_q),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .value_we    (value_we),
    .value_waddr (new_node),
    .value_wdata (store_value)
  );

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= CW'(NODES))
    else $error("fresh node count past pool size");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= fresh_count)
    else $error("more free nodes than ever handed out");

  a_pop_cmd: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (cmd_action == nsq_pkg::ACT_POP && nonempty && in_use))
    else $error("pop stage without a live pop");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  a_give_count: assert property (@(posedge clk) disable iff (rst)
    give_node |=> (free_count != '0))
    else $error("freed node not counted");

endmodule
`default_nettype wire
